@@ rtl/sdf_pkg.sv @@
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants for the sync/escape frame deframer.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned LenW    = 14;
  localparam int unsigned HdrLenW = 12;
  localparam int unsigned RunW    = 2;
  localparam int unsigned CfgIdxW = 2;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_SYNC_CHAR   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ESCAPE_CHAR = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SYNC_RUN    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_HUNT_LIMIT  = 2'd3;

  // register reset values
  localparam logic [ByteW-1:0] SYNC_CHAR_RST   = 8'h0D;
  localparam logic [ByteW-1:0] ESCAPE_CHAR_RST = 8'h10;
  localparam logic [RunW-1:0]  SYNC_RUN_RST    = 2'd3;
  localparam logic [ByteW-1:0] HUNT_LIMIT_RST  = 8'd50;

  // result kinds
  localparam logic [KindW-1:0] KIND_HEADER  = 2'd0;
  localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KindW-1:0] KIND_ERROR   = 2'd2;

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_HEAD = 2'd1,
    MODE_DATA = 2'd2
  } mode_t;

  typedef struct packed {
    logic [ByteW-1:0] sync_char;
    logic [ByteW-1:0] escape_char;
    logic [RunW-1:0]  sync_run;
    logic [ByteW-1:0] hunt_limit;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] frame_type;
    logic [LenW-1:0]  payload_len;
    logic             last;
  } res_t;

endpackage

@@ rtl/sync_escaped_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// sync_escaped_frame_deframer
// Hunts for a sync run, decodes an escaped four-byte header, streams payload.
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle while in_ready is high and gives
// at most one result per byte: a header result (message type and payload
// length), each payload byte with last on the final one, or an error when
// the hunt limit runs out. The per-byte step is combinational logic from
// the state registers to the result register; a two-entry output buffer
// (result register plus skid) catches the result produced while out_ready
// stalls, after which in_ready drops until the skid entry drains, so the
// sustained rate is one byte per cycle whenever results are taken. Each
// accepted result is registered in the result register or in the skid.
module sync_escaped_frame_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sdf_pkg::ByteW-1:0]   in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sdf_pkg::KindW-1:0]   out_kind,
  output logic [sdf_pkg::ByteW-1:0]   out_payload_byte,
  output logic [sdf_pkg::ByteW-1:0]   out_frame_type,
  output logic [sdf_pkg::LenW-1:0]    out_payload_len,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [sdf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [sdf_pkg::ByteW-1:0]   cfg_wdata
);
  import sdf_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic in_fire;
  logic res_valid;
  res_t res;
  res_t out_res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_CHAR:   cfg_nxt.sync_char   = cfg_wdata;
        REG_ESCAPE_CHAR: cfg_nxt.escape_char = cfg_wdata;
        REG_SYNC_RUN:    cfg_nxt.sync_run    = cfg_wdata[RunW-1:0];
        REG_HUNT_LIMIT:  cfg_nxt.hunt_limit  = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_char   <= SYNC_CHAR_RST;
      cfg_r.escape_char <= ESCAPE_CHAR_RST;
      cfg_r.sync_run    <= SYNC_RUN_RST;
      cfg_r.hunt_limit  <= HUNT_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_fire = in_valid && in_ready;

  sdf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_fire   (in_fire),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sdf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && res_valid),
    .push_res  (res),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_payload_byte = out_res.payload_byte;
  assign out_frame_type   = out_res.frame_type;
  assign out_payload_len  = out_res.payload_len;
  assign out_last         = out_res.last;

endmodule

@@ rtl/sdf_core.sv @@
// ----------------------------------------------------------------------------
// sdf_core
// Deframer state and the per-byte step: hunt, header collect, payload pass.
// ----------------------------------------------------------------------------
module sdf_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sdf_pkg::cfg_t             cfg,
  input  logic                      in_fire,
  input  logic [sdf_pkg::ByteW-1:0] rx_byte,
  output logic                      res_valid,
  output sdf_pkg::res_t             res
);
  import sdf_pkg::*;

  mode_t              mode_r, mode_nxt;
  logic [RunW-1:0]    sync_seen_r, sync_seen_nxt;
  logic [ByteW-1:0]   hunt_count_r, hunt_count_nxt;
  logic               esc_pend_r, esc_pend_nxt;
  logic [1:0]         hdr_idx_r, hdr_idx_nxt;
  logic [HdrLenW-1:0] hdr_len_r, hdr_len_nxt;
  logic [LenW-1:0]    bytes_left_r, bytes_left_nxt;

  logic [ByteW-1:0]   hc_v;
  logic [RunW-1:0]    ss_v;
  logic [RunW-1:0]    ss_inc;
  logic [RunW-1:0]    need;
  logic [LenW-1:0]    frame_len;
  logic               fin;

  assign need      = (cfg.sync_run == '0) ? RunW'(1) : cfg.sync_run;
  assign frame_len = {hdr_len_r, 2'b00};
  assign fin       = (bytes_left_r <= LenW'(1));

  always_comb begin
    mode_nxt       = mode_r;
    sync_seen_nxt  = sync_seen_r;
    hunt_count_nxt = hunt_count_r;
    esc_pend_nxt   = esc_pend_r;
    hdr_idx_nxt    = hdr_idx_r;
    hdr_len_nxt    = hdr_len_r;
    bytes_left_nxt = bytes_left_r;
    res_valid      = 1'b0;
    res            = '0;
    hc_v           = hunt_count_r;
    ss_v           = sync_seen_r;
    ss_inc         = '0;
    unique case (mode_r)
      MODE_HEAD: begin
        if (!esc_pend_r && rx_byte == cfg.sync_char) begin
          // bare sync inside the header is dropped
        end else if (!esc_pend_r && rx_byte == cfg.escape_char) begin
          esc_pend_nxt = 1'b1;
        end else begin
          esc_pend_nxt = 1'b0;
          if (hdr_idx_r == 2'd0) hdr_len_nxt[7:0] = rx_byte;
          if (hdr_idx_r == 2'd1) hdr_len_nxt[HdrLenW-1:8] = rx_byte[HdrLenW-9:0];
          if (hdr_idx_r == 2'd3) begin
            // fourth byte is the message type and closes the header
            res_valid       = 1'b1;
            res.kind        = KIND_HEADER;
            res.frame_type  = rx_byte;
            res.payload_len = frame_len;
            res.last        = (frame_len == '0);
            hdr_idx_nxt     = 2'd0;
            if (frame_len == '0) begin
              mode_nxt       = MODE_HUNT;
              sync_seen_nxt  = '0;
              hunt_count_nxt = '0;
              hdr_len_nxt    = '0;
              bytes_left_nxt = '0;
            end else begin
              mode_nxt       = MODE_DATA;
              bytes_left_nxt = frame_len;
            end
          end else begin
            hdr_idx_nxt = hdr_idx_r + 2'd1;
          end
        end
      end
      MODE_DATA: begin
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = rx_byte;
        res.last         = fin;
        if (fin) begin
          mode_nxt       = MODE_HUNT;
          sync_seen_nxt  = '0;
          hunt_count_nxt = '0;
          esc_pend_nxt   = 1'b0;
          hdr_idx_nxt    = '0;
          hdr_len_nxt    = '0;
          bytes_left_nxt = '0;
        end else begin
          bytes_left_nxt = bytes_left_r - LenW'(1);
        end
      end
      default: begin
        mode_nxt = MODE_HUNT;
        if (hunt_count_r >= cfg.hunt_limit) begin
          // limit hit: report, restart, then treat this byte as a fresh hunt byte
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          hc_v           = '0;
          ss_v           = '0;
          esc_pend_nxt   = 1'b0;
          hdr_idx_nxt    = '0;
          hdr_len_nxt    = '0;
          bytes_left_nxt = '0;
        end
        hunt_count_nxt = hc_v + ByteW'(1);
        ss_inc         = ss_v + RunW'(1);
        if (rx_byte == cfg.sync_char) begin
          if (ss_inc >= need) begin
            mode_nxt      = MODE_HEAD;
            sync_seen_nxt = '0;
            esc_pend_nxt  = 1'b0;
            hdr_idx_nxt   = '0;
            hdr_len_nxt   = '0;
          end else begin
            sync_seen_nxt = ss_inc;
          end
        end else begin
          sync_seen_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_HUNT;
      sync_seen_r  <= '0;
      hunt_count_r <= '0;
      esc_pend_r   <= 1'b0;
      hdr_idx_r    <= '0;
      hdr_len_r    <= '0;
      bytes_left_r <= '0;
    end else if (in_fire) begin
      mode_r       <= mode_nxt;
      sync_seen_r  <= sync_seen_nxt;
      hunt_count_r <= hunt_count_nxt;
      esc_pend_r   <= esc_pend_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      hdr_len_r    <= hdr_len_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  // payload mode always has bytes still owed
  a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DATA |-> bytes_left_r != '0)
    else $error("payload mode with zero bytes left");

  // a completed run leaves hunting, so the count never reaches three
  a_sync_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    sync_seen_r != 2'd3)
    else $error("sync run count out of range");

  // a payload byte marked last sends the block back to hunting
  a_last_payload_ends: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && mode_r == MODE_DATA && fin |=> mode_r == MODE_HUNT && hunt_count_r == '0)
    else $error("frame end did not restart the hunt");

endmodule

@@ rtl/sdf_out_buf.sv @@
// ----------------------------------------------------------------------------
// sdf_out_buf
// Result register with a skid stage; an output stall drops can_take until the skid drains.
// ----------------------------------------------------------------------------
module sdf_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sdf_pkg::res_t push_res,
  output logic          can_take,
  output logic          out_valid,
  input  logic          out_ready,
  output sdf_pkg::res_t out_res
);
  import sdf_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;
  logic pop;

  assign pop       = out_valid_r && out_ready;
  assign can_take  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_res_nxt   = push_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  // skid entry only exists behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item with the output empty");

  // a push while full would drop an item
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_take)
    else $error("result pushed into a full buffer");

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_res_r))
    else $error("held result changed before it was taken");

endmodule

@@ test/tb_sync_escaped_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// tb_sync_escaped_frame_deframer
// Self-checking testbench for the sync/escape frame deframer.
// ----------------------------------------------------------------------------
// Bytes go in over a valid/ready channel. A behavioral deframer in this file
// follows every accepted byte and queues the result it should cause. A
// checker pops that queue on every accepted result and compares each field.
// Directed tests cover escaped headers, zero-length and long frames, the
// hunt limit (zero included), a zero sync run and a sync char that equals the
// escape char. Random traffic then mixes well-formed frames with noise,
// partial sync runs and hunt overruns under several register settings and
// idle/stall patterns, and one test holds off the receiver so the block
// fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_sync_escaped_frame_deframer;
  import sdf_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 4;
  localparam int ReportLimit = 10;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ByteW-1:0]  in_rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [KindW-1:0]  out_kind;
  logic [ByteW-1:0]  out_payload_byte;
  logic [ByteW-1:0]  out_frame_type;
  logic [LenW-1:0]   out_payload_len;
  logic              out_last;
  logic              cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0]  cfg_wdata = '0;

  sync_escaped_frame_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_type   (out_frame_type),
    .out_payload_len  (out_payload_len),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror
  logic [ByteW-1:0] cfg_sync;
  logic [ByteW-1:0] cfg_escape;
  logic [RunW-1:0]  cfg_run;
  logic [ByteW-1:0] cfg_hunt_limit;

  // deframer state mirror
  mode_t            fr_mode;
  logic [1:0]       fr_sync_seen;
  logic [ByteW-1:0] fr_hunt_count;
  logic             fr_esc_pending;
  logic [2:0]       fr_hdr_index;
  logic [31:0]      fr_hdr_word;
  logic [LenW-1:0]  fr_bytes_left;

  res_t expected_results [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_left = 0;
  int bytes_sent = 0;
  int failures = 0;
  int headers_seen = 0;
  int payload_seen = 0;
  int hunt_errors_seen = 0;
  int quiet_cycles = 0;

  function automatic void clear_hunt();
    fr_mode        = MODE_HUNT;
    fr_sync_seen   = '0;
    fr_hunt_count  = '0;
    fr_esc_pending = 1'b0;
    fr_hdr_index   = '0;
    fr_hdr_word    = '0;
    fr_bytes_left  = '0;
  endfunction

  // advance the mirror by one byte, queueing the result it causes
  function automatic void deframe_byte(logic [ByteW-1:0] b);
    res_t r;
    logic [LenW-1:0] len;
    logic [1:0] need;
    r = '0;
    if (fr_mode == MODE_HEAD) begin
      if (!fr_esc_pending && b == cfg_sync) return;
      if (!fr_esc_pending && b == cfg_escape) begin
        fr_esc_pending = 1'b1;
        return;
      end
      fr_esc_pending = 1'b0;
      fr_hdr_word = fr_hdr_word | (32'(b) << (8 * fr_hdr_index[1:0]));
      fr_hdr_index = fr_hdr_index + 3'd1;
      if (fr_hdr_index < 3'd4) return;
      len = {fr_hdr_word[11:0], 2'b00};
      r.kind = KIND_HEADER;
      r.frame_type = fr_hdr_word[31:24];
      r.payload_len = len;
      r.last = (len == '0);
      expected_results.push_back(r);
      if (len == '0) begin
        clear_hunt();
      end else begin
        fr_mode = MODE_DATA;
        fr_bytes_left = len;
        fr_hdr_index = '0;
      end
    end else if (fr_mode == MODE_DATA) begin
      r.kind = KIND_PAYLOAD;
      r.payload_byte = b;
      r.last = (fr_bytes_left <= 1);
      expected_results.push_back(r);
      if (r.last) clear_hunt();
      else fr_bytes_left = fr_bytes_left - 1'b1;
    end else begin
      fr_mode = MODE_HUNT;
      if (fr_hunt_count >= cfg_hunt_limit) begin
        r.kind = KIND_ERROR;
        expected_results.push_back(r);
        clear_hunt();
      end
      fr_hunt_count = fr_hunt_count + 1'b1;
      if (b == cfg_sync) begin
        need = (cfg_run == '0) ? 2'd1 : cfg_run;
        fr_sync_seen = fr_sync_seen + 2'd1;
        if (fr_sync_seen >= need) begin
          fr_mode = MODE_HEAD;
          fr_sync_seen = '0;
          fr_esc_pending = 1'b0;
          fr_hdr_index = '0;
          fr_hdr_word = '0;
        end
      end else begin
        fr_sync_seen = '0;
      end
    end
  endfunction

  function automatic logic [ByteW-1:0] noise_byte();
    logic [ByteW-1:0] b;
    b = 8'($urandom);
    if (b == cfg_sync) b = ~b;
    return b;
  endfunction

  // offer one item and hold it until accepted; valid stays high afterwards
  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // drop valid, let every expected result drain, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_config(input logic [ByteW-1:0] sync_c, input logic [ByteW-1:0] esc_c,
                            input logic [RunW-1:0] run, input logic [ByteW-1:0] limit);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_SYNC_CHAR;
    cfg_wdata <= sync_c;
    @(posedge clk);
    cfg_sync = sync_c;
    cfg_index <= REG_ESCAPE_CHAR;
    cfg_wdata <= esc_c;
    @(posedge clk);
    cfg_escape = esc_c;
    cfg_index <= REG_SYNC_RUN;
    cfg_wdata <= 8'(run);
    @(posedge clk);
    cfg_run = run;
    cfg_index <= REG_HUNT_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_hunt_limit = limit;
    cfg_we <= 1'b0;
  endtask

  // noise, sync run, escaped header, random payload
  task automatic send_frame(input logic [31:0] hdr, input int noise_len,
                            input bit bare_syncs);
    int run_len;
    logic [ByteW-1:0] v;
    logic [LenW-1:0] plen;
    run_len = (cfg_run == '0) ? 1 : int'(cfg_run);
    repeat (noise_len) send_byte(noise_byte());
    // keep the hunt limit from breaking the run
    while (int'(cfg_hunt_limit) >= run_len && fr_mode == MODE_HUNT &&
           fr_hunt_count < cfg_hunt_limit &&
           int'(fr_hunt_count) + run_len > int'(cfg_hunt_limit))
      send_byte(noise_byte());
    repeat (run_len) send_byte(cfg_sync);
    for (int i = 0; i < 4; i++) begin
      v = hdr[8*i +: 8];
      if (bare_syncs && $urandom_range(4) == 0) send_byte(cfg_sync);
      if (v == cfg_sync || v == cfg_escape) begin
        if (cfg_sync != cfg_escape) send_byte(cfg_escape);
        else v = v ^ 8'h01;
      end
      send_byte(v);
    end
    plen = {hdr[11:0], 2'b00};
    repeat (plen) send_byte(8'($urandom));
  endtask

  task automatic run_traffic(input int n_items);
    int start_count;
    int pick;
    int need;
    logic [31:0] hdr;
    start_count = bytes_sent;
    while (bytes_sent - start_count < n_items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        hdr = $urandom;
        hdr[11:0] = ($urandom_range(9) == 0) ? 12'($urandom_range(40))
                                             : 12'($urandom_range(6));
        send_frame(hdr, $urandom_range(4), 1'($urandom_range(1)));
      end else if (pick < 88) begin
        // partial sync run that falls back to hunting
        need = (cfg_run == '0) ? 1 : int'(cfg_run);
        repeat ($urandom_range(need - 1)) send_byte(cfg_sync);
        send_byte(noise_byte());
      end else if (cfg_hunt_limit <= 60) begin
        repeat (int'(cfg_hunt_limit) + 1) send_byte(noise_byte());
      end else begin
        repeat (12) send_byte(noise_byte());
      end
    end
  endtask

  task automatic test_escaped_header();
    // escaped escape and sync chars plus a bare sync inside the header
    repeat (3) send_byte(SYNC_CHAR_RST);
    send_byte(8'h01);
    send_byte(ESCAPE_CHAR_RST);
    send_byte(8'h10);
    send_byte(SYNC_CHAR_RST);
    send_byte(8'hFF);
    send_byte(ESCAPE_CHAR_RST);
    send_byte(SYNC_CHAR_RST);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_CHAR_RST);
    send_byte(ESCAPE_CHAR_RST);
    // zero-length frame ends on its header
    repeat (3) send_byte(SYNC_CHAR_RST);
    repeat (3) send_byte(8'h00);
    send_byte(8'h7E);
  endtask

  task automatic test_hunt_limit();
    // zero limit: every hunting byte errors, the sync byte still starts a header
    set_config(SYNC_CHAR_RST, ESCAPE_CHAR_RST, 2'd1, 8'd0);
    send_byte(8'h33);
    send_byte(SYNC_CHAR_RST);
    repeat (4) send_byte(8'h00);
    // the byte that hits the limit is reused as the first of the new hunt
    set_config(SYNC_CHAR_RST, ESCAPE_CHAR_RST, 2'd1, 8'd2);
    send_byte(8'h33);
    send_byte(8'h44);
    send_byte(SYNC_CHAR_RST);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h42);
    repeat (4) send_byte(8'($urandom));
  endtask

  task automatic test_sync_is_escape();
    // zero sync run acts as one; the shared char is always skipped in the header
    set_config(8'h5A, 8'h5A, 2'd0, 8'd50);
    send_byte(8'h5A);
    send_byte(8'h01);
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'h99);
    send_byte(8'h5A);
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_long_frame();
    // upper nibble of header byte one must not reach the length
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(SYNC_CHAR_RST, ESCAPE_CHAR_RST, SYNC_RUN_RST, HUNT_LIMIT_RST);
    send_frame(32'hC35A_F030, 0, 1'b0);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    hold_off_left = 300;
    send_frame(32'h2100_000A, 0, 1'b0);
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(SYNC_CHAR_RST, ESCAPE_CHAR_RST, SYNC_RUN_RST, HUNT_LIMIT_RST);
    run_traffic(80);
    send_idle_pct = 56;
    set_config(8'h7E, 8'h7D, 2'd1, 8'd12);
    run_traffic(80);
    send_idle_pct = 0;
    recv_stall_pct = 56;
    set_config(8'hFF, 8'h00, 2'd2, 8'd255);
    run_traffic(80);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    set_config(8'h00, 8'hFF, 2'd3, 8'd9);
    run_traffic(80);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(8'($urandom), 8'($urandom), 2'($urandom_range(3)),
               8'($urandom_range(8, 255)));
    run_traffic(80);
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("unexpected result: kind %0d byte %h type %h len %0d last %0d",
                   out_kind, out_payload_byte, out_frame_type, out_payload_len, out_last);
      end else begin
        want = expected_results.pop_front();
        if (out_kind !== want.kind || out_payload_byte !== want.payload_byte ||
            out_frame_type !== want.frame_type || out_payload_len !== want.payload_len ||
            out_last !== want.last) begin
          failures++;
          if (failures <= ReportLimit)
            $display("mismatch: exp %0d %h %h %0d %0d / got %0d %h %h %0d %0d",
                     want.kind, want.payload_byte, want.frame_type, want.payload_len,
                     want.last, out_kind, out_payload_byte, out_frame_type,
                     out_payload_len, out_last);
        end
      end
      case (out_kind)
        KIND_HEADER:  headers_seen++;
        KIND_PAYLOAD: payload_seen++;
        default:      hunt_errors_seen++;
      endcase
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: nothing accepted for %0d cycles", QuietLimit);
    $display("FAIL");
    $finish;
  end

  initial begin
    cfg_sync       = SYNC_CHAR_RST;
    cfg_escape     = ESCAPE_CHAR_RST;
    cfg_run        = SYNC_RUN_RST;
    cfg_hunt_limit = HUNT_LIMIT_RST;
    clear_hunt();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_escaped_header();
    test_hunt_limit();
    test_sync_is_escape();
    test_long_frame();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    $display("covered %0d bytes: %0d headers, %0d payload bytes, %0d hunt errors",
             bytes_sent, headers_seen, payload_seen, hunt_errors_seen);
    $display("%0d failures, %0d results still outstanding",
             failures, expected_results.size());
    if (failures == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
